>>> src/s2cd_pkg.sv
// ----------------------------------------------------------------------------
// s2cd_pkg
// Shared types, control word layout and calendar constants for the
// seconds-to-calendar-date converter.
// ----------------------------------------------------------------------------
package s2cd_pkg;

   localparam int PC_W = 4;

   // datapath operations, one per microcode step kind
   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_DIV,
      OP_SAVE_DAYS,
      OP_SAVE_WDAY,
      OP_SAVE_HOUR,
      OP_SAVE_MIN,
      OP_SAVE_QUAD,
      OP_YEAR,
      OP_SAVE_YDAY,
      OP_MONTH,
      OP_EMIT
   } op_type;

   // branch conditions: taken goes to addr, otherwise pc + 1
   typedef enum logic [2:0] {
      BR_NEXT,
      BR_IDLE,
      BR_GE,
      BR_BUSY,
      BR_JUMP
   } br_type;

   typedef enum logic [2:0] {
      DV_DAY,
      DV_WEEK,
      DV_HOUR,
      DV_MIN,
      DV_QUAD
   } dsel_type;

   typedef struct packed {
      op_type            op;
      br_type            br;
      logic [PC_W-1:0]   addr;
      dsel_type          dsel;
   } ucode_type;

   // sequencer to datapath
   typedef struct packed {
      op_type            op;
      dsel_type          dsel;
   } ctl_type;

   // datapath to sequencer
   typedef struct packed {
      logic accept;
      logic ge;
      logic busy;
   } sts_type;

   localparam logic [16:0] ZONE_RESET    = 17'd28800;
   localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
   localparam logic [16:0] DAYS_PER_WEEK = 17'd7;
   localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
   localparam logic [16:0] SECS_PER_MIN  = 17'd60;
   localparam logic [16:0] DAYS_PER_QUAD = 17'd1461;
   localparam logic [15:0] WDAY_BIAS     = 16'd6;
   // day count of 2100-03-01, the first day after the missing leap day
   localparam logic [15:0] DAYS_2100_MAR = 16'd36584;
   localparam logic [5:0]  QUAD_2100     = 6'd25;
   localparam logic [8:0]  YDAY_MAR_LEAP = 9'd60;
   localparam logic [8:0]  DAYS_YEAR     = 9'd365;
   localparam logic [8:0]  DAYS_LEAP     = 9'd366;
   localparam logic [7:0]  YEAR_BASE     = 8'd100;
   localparam logic [3:0]  MONTH_FEB     = 4'd1;
   localparam logic [3:0]  MONTH_DEC     = 4'd11;

   // reciprocal multipliers, exact over each dividend range
   // day: 675 after dropping 7 low bits, shift 35
   localparam logic [25:0] RCP_DAY  = 26'd50903317;
   // week: shift 19
   localparam logic [25:0] RCP_WEEK = 26'd74899;
   // hour: 225 after dropping 4 low bits, shift 21
   localparam logic [25:0] RCP_HOUR = 26'd9321;
   // minute: 15 after dropping 2 low bits, shift 14
   localparam logic [25:0] RCP_MIN  = 26'd1093;
   // four-year block: shift 27
   localparam logic [25:0] RCP_QUAD = 26'd91868;

   function automatic logic [16:0] divisor(input dsel_type sel);
      logic [16:0] d;
      case (sel)
         DV_DAY:  d = SECS_PER_DAY;
         DV_WEEK: d = DAYS_PER_WEEK;
         DV_HOUR: d = SECS_PER_HOUR;
         DV_MIN:  d = SECS_PER_MIN;
         DV_QUAD: d = DAYS_PER_QUAD;
         default: d = SECS_PER_DAY;
      endcase
      return d;
   endfunction

   function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
      logic [4:0] n;
      case (mon) inside
         MONTH_FEB:                   n = leap ? 5'd29 : 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10:     n = 5'd30;
         default:                     n = 5'd31;
      endcase
      return n;
   endfunction

endpackage

>>> src/s2cd_seq.sv
// ----------------------------------------------------------------------------
// s2cd_seq
// Microcode sequencer: program ROM and program counter.
// ----------------------------------------------------------------------------
module s2cd_seq (
   input  logic                clock,
   input  logic                reset,
   input  s2cd_pkg::sts_type   sts,
   output s2cd_pkg::ctl_type   ctl
);

   logic [s2cd_pkg::PC_W-1:0]  pc_ff, pc_in;
   s2cd_pkg::ucode_type        word;
   logic                       taken;

   function automatic s2cd_pkg::ucode_type rom(input logic [s2cd_pkg::PC_W-1:0] pc);
      s2cd_pkg::ucode_type w;
      case (pc)
         4'd0:  w = '{s2cd_pkg::OP_LOAD,      s2cd_pkg::BR_IDLE, 4'd0,  s2cd_pkg::DV_DAY};
         4'd1:  w = '{s2cd_pkg::OP_DIV,       s2cd_pkg::BR_NEXT, 4'd0,  s2cd_pkg::DV_DAY};
         4'd2:  w = '{s2cd_pkg::OP_SAVE_DAYS, s2cd_pkg::BR_NEXT, 4'd0,  s2cd_pkg::DV_DAY};
         4'd3:  w = '{s2cd_pkg::OP_DIV,       s2cd_pkg::BR_NEXT, 4'd0,  s2cd_pkg::DV_WEEK};
         4'd4:  w = '{s2cd_pkg::OP_SAVE_WDAY, s2cd_pkg::BR_NEXT, 4'd0,  s2cd_pkg::DV_WEEK};
         4'd5:  w = '{s2cd_pkg::OP_DIV,       s2cd_pkg::BR_NEXT, 4'd0,  s2cd_pkg::DV_HOUR};
         4'd6:  w = '{s2cd_pkg::OP_SAVE_HOUR, s2cd_pkg::BR_NEXT, 4'd0,  s2cd_pkg::DV_HOUR};
         4'd7:  w = '{s2cd_pkg::OP_DIV,       s2cd_pkg::BR_NEXT, 4'd0,  s2cd_pkg::DV_MIN};
         4'd8:  w = '{s2cd_pkg::OP_SAVE_MIN,  s2cd_pkg::BR_NEXT, 4'd0,  s2cd_pkg::DV_MIN};
         4'd9:  w = '{s2cd_pkg::OP_DIV,       s2cd_pkg::BR_NEXT, 4'd0,  s2cd_pkg::DV_QUAD};
         4'd10: w = '{s2cd_pkg::OP_SAVE_QUAD, s2cd_pkg::BR_NEXT, 4'd0,  s2cd_pkg::DV_QUAD};
         4'd11: w = '{s2cd_pkg::OP_YEAR,      s2cd_pkg::BR_GE,   4'd11, s2cd_pkg::DV_DAY};
         4'd12: w = '{s2cd_pkg::OP_SAVE_YDAY, s2cd_pkg::BR_NEXT, 4'd0,  s2cd_pkg::DV_DAY};
         4'd13: w = '{s2cd_pkg::OP_MONTH,     s2cd_pkg::BR_GE,   4'd13, s2cd_pkg::DV_DAY};
         4'd14: w = '{s2cd_pkg::OP_EMIT,      s2cd_pkg::BR_BUSY, 4'd14, s2cd_pkg::DV_DAY};
         default: w = '{s2cd_pkg::OP_NOP,     s2cd_pkg::BR_JUMP, 4'd0,  s2cd_pkg::DV_DAY};
      endcase
      return w;
   endfunction

   assign word = rom(pc_ff);

   assign ctl.op   = word.op;
   assign ctl.dsel = word.dsel;

   always_comb begin
      case (word.br)
         s2cd_pkg::BR_NEXT: taken = 1'b0;
         s2cd_pkg::BR_IDLE: taken = !sts.accept;
         s2cd_pkg::BR_GE:   taken = sts.ge;
         s2cd_pkg::BR_BUSY: taken = sts.busy;
         s2cd_pkg::BR_JUMP: taken = 1'b1;
         default:           taken = 1'b0;
      endcase
   end

   assign pc_in = taken ? word.addr : pc_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

>>> src/s2cd_datapath.sv
// ----------------------------------------------------------------------------
// s2cd_datapath
// Working registers, reciprocal-multiply divider, shared compare-subtract
// unit and result register, steered by the sequencer's control word.
// ----------------------------------------------------------------------------
module s2cd_datapath (
   input  logic                clock,
   input  logic                reset,
   input  s2cd_pkg::ctl_type   ctl,
   input  logic [16:0]         zone,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [31:0]         req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [47:0]         rsp_tdata,
   output s2cd_pkg::sts_type   sts
);

   logic [31:0] rem_ff,   rem_in;
   logic [15:0] quo_ff,   quo_in;
   logic [15:0] days_ff,  days_in;
   logic [16:0] secs_ff,  secs_in;
   logic [2:0]  wday_ff,  wday_in;
   logic [4:0]  hour_ff,  hour_in;
   logic [5:0]  min_ff,   min_in;
   logic [5:0]  sec_ff,   sec_in;
   logic [5:0]  quad_ff,  quad_in;
   logic [1:0]  yoff_ff,  yoff_in;
   logic [8:0]  yday_ff,  yday_in;
   logic [3:0]  mon_ff,   mon_in;
   logic [47:0] data_ff,  data_in;
   logic        valid_ff, valid_in;

   logic        accept, busy, leap, no_borrow, ge, fix_2100;
   logic [4:0]  mlen;
   logic [8:0]  ylen;
   logic [31:0] sub_val;
   logic [32:0] diff;
   logic [15:0] fake_days;
   logic [7:0]  year;
   logic [24:0] div_x;
   logic [25:0] div_m;
   logic [50:0] prod;
   logic [15:0] div_q;
   logic [31:0] qd;
   logic [31:0] modv;

   assign req_tready = (ctl.op == s2cd_pkg::OP_LOAD);
   assign accept     = req_tvalid && req_tready;
   assign busy       = valid_ff && !rsp_tready;

   // 2100 is counted as leap here; the extra day is taken out of day_of_year
   assign leap      = (yoff_ff == 2'd0);
   assign mlen      = s2cd_pkg::month_days(mon_ff, leap);
   assign ylen      = leap ? s2cd_pkg::DAYS_LEAP : s2cd_pkg::DAYS_YEAR;
   assign fake_days = days_ff + {15'd0, days_ff >= s2cd_pkg::DAYS_2100_MAR};
   assign fix_2100  = (quad_ff == s2cd_pkg::QUAD_2100) && leap
                      && (rem_ff[8:0] >= s2cd_pkg::YDAY_MAR_LEAP);
   assign year      = s2cd_pkg::YEAR_BASE + {quad_ff, 2'b00} + {6'd0, yoff_ff};

   // quotient by multiply with a scaled reciprocal, low factors of two dropped first
   always_comb begin
      case (ctl.dsel)
         s2cd_pkg::DV_DAY: begin
            div_x = rem_ff[31:7];
            div_m = s2cd_pkg::RCP_DAY;
         end
         s2cd_pkg::DV_WEEK: begin
            div_x = {9'd0, rem_ff[15:0]};
            div_m = s2cd_pkg::RCP_WEEK;
         end
         s2cd_pkg::DV_HOUR: begin
            div_x = {12'd0, rem_ff[16:4]};
            div_m = s2cd_pkg::RCP_HOUR;
         end
         s2cd_pkg::DV_MIN: begin
            div_x = {15'd0, rem_ff[11:2]};
            div_m = s2cd_pkg::RCP_MIN;
         end
         s2cd_pkg::DV_QUAD: begin
            div_x = {9'd0, rem_ff[15:0]};
            div_m = s2cd_pkg::RCP_QUAD;
         end
         default: begin
            div_x = rem_ff[31:7];
            div_m = s2cd_pkg::RCP_DAY;
         end
      endcase
   end

   assign prod = {26'd0, div_x} * {25'd0, div_m};

   always_comb begin
      case (ctl.dsel)
         s2cd_pkg::DV_DAY:  div_q = prod[50:35];
         s2cd_pkg::DV_WEEK: div_q = prod[34:19];
         s2cd_pkg::DV_HOUR: div_q = prod[36:21];
         s2cd_pkg::DV_MIN:  div_q = prod[29:14];
         s2cd_pkg::DV_QUAD: div_q = prod[42:27];
         default:           div_q = prod[50:35];
      endcase
   end

   // remainder from the quotient saved on the previous step
   assign qd   = {16'd0, quo_ff} * {15'd0, s2cd_pkg::divisor(ctl.dsel)};
   assign modv = rem_ff - qd;

   always_comb begin
      case (ctl.op)
         s2cd_pkg::OP_YEAR:  sub_val = {23'd0, ylen};
         s2cd_pkg::OP_MONTH: sub_val = {27'd0, mlen};
         default:            sub_val = '0;
      endcase
   end

   assign diff      = {1'b0, rem_ff} - {1'b0, sub_val};
   assign no_borrow = !diff[32];
   assign ge        = (ctl.op == s2cd_pkg::OP_MONTH)
                      ? (no_borrow && mon_ff != s2cd_pkg::MONTH_DEC)
                      : no_borrow;

   assign sts.accept = accept;
   assign sts.ge     = ge;
   assign sts.busy   = busy;

   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      days_in  = days_ff;
      secs_in  = secs_ff;
      wday_in  = wday_ff;
      hour_in  = hour_ff;
      min_in   = min_ff;
      sec_in   = sec_ff;
      quad_in  = quad_ff;
      yoff_in  = yoff_ff;
      yday_in  = yday_ff;
      mon_in   = mon_ff;
      data_in  = data_ff;
      valid_in = valid_ff && !rsp_tready;
      case (ctl.op)
         s2cd_pkg::OP_LOAD: begin
            if (accept) begin
               rem_in = req_tdata + {15'd0, zone};
               quo_in = '0;
            end
         end
         s2cd_pkg::OP_DIV: begin
            quo_in = div_q;
         end
         s2cd_pkg::OP_SAVE_DAYS: begin
            secs_in = modv[16:0];
            days_in = quo_ff;
            rem_in  = {16'd0, quo_ff + s2cd_pkg::WDAY_BIAS};
            quo_in  = '0;
         end
         s2cd_pkg::OP_SAVE_WDAY: begin
            wday_in = modv[2:0];
            rem_in  = {15'd0, secs_ff};
            quo_in  = '0;
         end
         s2cd_pkg::OP_SAVE_HOUR: begin
            hour_in = quo_ff[4:0];
            rem_in  = modv;
            quo_in  = '0;
         end
         s2cd_pkg::OP_SAVE_MIN: begin
            min_in = quo_ff[5:0];
            sec_in = modv[5:0];
            rem_in = {16'd0, fake_days};
            quo_in = '0;
         end
         s2cd_pkg::OP_SAVE_QUAD: begin
            quad_in = quo_ff[5:0];
            rem_in  = modv;
            yoff_in = '0;
         end
         s2cd_pkg::OP_YEAR: begin
            if (no_borrow) begin
               rem_in  = diff[31:0];
               yoff_in = yoff_ff + 2'd1;
            end
         end
         s2cd_pkg::OP_SAVE_YDAY: begin
            yday_in = rem_ff[8:0] - {8'd0, fix_2100};
            mon_in  = '0;
         end
         s2cd_pkg::OP_MONTH: begin
            if (ge) begin
               rem_in = diff[31:0];
               mon_in = mon_ff + 4'd1;
            end
         end
         s2cd_pkg::OP_EMIT: begin
            if (!busy) begin
               data_in  = {2'b00, wday_ff, yday_ff, year, mon_ff,
                           rem_ff[4:0] + 5'd1, hour_ff, min_ff, sec_ff};
               valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      days_ff <= days_in;
      secs_ff <= secs_in;
      wday_ff <= wday_in;
      hour_ff <= hour_in;
      min_ff  <= min_in;
      sec_ff  <= sec_in;
      quad_ff <= quad_in;
      yoff_ff <= yoff_in;
      yday_ff <= yday_in;
      mon_ff  <= mon_in;
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

>>> src/seconds_to_calendar_date_top.sv
// ----------------------------------------------------------------------------
// seconds_to_calendar_date_top
// Converts a count of seconds since 2000-01-01 plus a time-zone offset into
// local time of day and Gregorian calendar date.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake              payload
//   req       in    req_tvalid/tready      second_count
//   rsp       out   rsp_tvalid/tready      time and date fields
//   csr       in    csr_valid/ready        zone_offset_seconds
//
// an item goes from acceptance to result in steps: ten fixed steps
// split the count by reciprocal multiplies, a quotient and a remainder step
// per divisor, then up to 3 years and 11 months are stepped off one a cycle
// and one step loads the output register. a jump step then returns to the
// input wait step, which takes the next transaction while the result waits;
// a result still unread at the next load step holds the program there.
// reset restores 28800 as zone offset and the program to the input wait step.
//
module seconds_to_calendar_date_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] second_count
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [5:0] second_of_minute, [11:6] minute_of_hour, [16:12] hour_of_day,
   // [21:17] day_of_month, [25:22] month_index, [33:26] years_since_1900,
   // [42:34] day_of_year, [45:43] weekday, [47:46] zero
   output logic [47:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [16:0] csr_data     // [16:0] zone_offset_seconds
);

   logic [16:0]         zone_ff, zone_in;
   s2cd_pkg::ctl_type   ctl;
   s2cd_pkg::sts_type   sts;

   assign csr_ready = 1'b1;
   assign zone_in   = (csr_valid && csr_ready) ? csr_data : zone_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff <= s2cd_pkg::ZONE_RESET;
      end else begin
         zone_ff <= zone_in;
      end
   end

   s2cd_seq u_seq (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .ctl   (ctl)
   );

   s2cd_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .zone       (zone_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .sts        (sts)
   );

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the seconds-to-calendar-date converter. A queue of
// second counts feeds a stream driver; each accepted count is converted by a
// local calendar model under the current zone offset, and a monitor compares
// every result against the oldest pending date. The run walks through several
// offset settings, directed calendar corners and random counts, with random
// idle cycles on both the input and the result side.
// ----------------------------------------------------------------------------
module tb;

   localparam int unsigned DAY_SECONDS = 86400;

   typedef struct packed {
      logic [2:0] weekday;
      logic [8:0] day_of_year;
      logic [7:0] years_since_1900;
      logic [3:0] month_index;
      logic [4:0] day_of_month;
      logic [4:0] hour_of_day;
      logic [5:0] minute_of_hour;
      logic [5:0] second_of_minute;
   } date_t;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [16:0] csr_data   = '0;

   logic [16:0] zone_offset = s2cd_pkg::ZONE_RESET;
   logic [31:0] pending_counts[$];
   date_t       expected_dates[$];
   int          n_queued      = 0;
   int          n_checked     = 0;
   int          fail_count    = 0;
   int          n_zones       = 1;
   int          req_gap       = 0;
   int          rsp_stall     = 0;
   int          req_gap_max   = 0;
   int          rsp_stall_max = 0;

   seconds_to_calendar_date_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   function automatic bit is_leap(input int unsigned year);
      return (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
   endfunction

   // days from 2000-01-01 to january first of the given year
   function automatic int unsigned year_start(input int unsigned year);
      int unsigned d;
      d = 0;
      for (int unsigned y = 2000; y < year; y++) d += is_leap(y) ? 366 : 365;
      return d;
   endfunction

   function automatic date_t to_calendar(input logic [31:0] count, input logic [16:0] zone);
      int unsigned month_len[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      logic [31:0] local_secs;
      int unsigned days, sod, year, ylen, mon, mlen;
      date_t r;
      local_secs = count + {15'd0, zone};
      days = local_secs / DAY_SECONDS;
      sod  = local_secs % DAY_SECONDS;
      r.weekday = 3'((days + 6) % 7);
      year = 2000;
      ylen = is_leap(year) ? 366 : 365;
      while (days >= ylen) begin
         days -= ylen;
         year++;
         ylen = is_leap(year) ? 366 : 365;
      end
      r.day_of_year = 9'(days);
      mon = 0;
      while (mon < 11) begin
         mlen = month_len[mon] + ((mon == 1 && is_leap(year)) ? 1 : 0);
         if (days < mlen) break;
         days -= mlen;
         mon++;
      end
      r.second_of_minute = 6'(sod % 60);
      r.minute_of_hour   = 6'((sod / 60) % 60);
      r.hour_of_day      = 5'(sod / 3600);
      r.day_of_month     = 5'(days + 1);
      r.month_index      = 4'(mon);
      r.years_since_1900 = 8'(year - 1900);
      return r;
   endfunction

   function automatic string fmt_date(input date_t d);
      return $sformatf("y%0d m%0d d%0d yd%0d wd%0d %0d:%0d:%0d",
                       d.years_since_1900, d.month_index, d.day_of_month, d.day_of_year,
                       d.weekday, d.hour_of_day, d.minute_of_hour, d.second_of_minute);
   endfunction

   // input driver: one transaction per queued count, random gap between items
   always @(posedge clock) begin : req_driver
      logic nxt_valid;
      nxt_valid = req_tvalid;
      if (reset) begin
         nxt_valid = 1'b0;
         req_gap   = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_dates.push_back(to_calendar(req_tdata, zone_offset));
            nxt_valid = 1'b0;
         end
         if (!nxt_valid) begin
            if (req_gap != 0) begin
               req_gap--;
            end else if (pending_counts.size() != 0) begin
               req_tdata <= pending_counts.pop_front();
               nxt_valid = 1'b1;
               req_gap   = $urandom_range(0, req_gap_max);
            end
         end
      end
      req_tvalid <= nxt_valid;
   end

   // result monitor with random back-pressure
   always @(posedge clock) begin : rsp_monitor
      date_t want;
      logic  nxt_ready;
      if (reset) begin
         nxt_ready = 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_dates.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result %h at %0t", rsp_tdata, $realtime);
            end else begin
               want = expected_dates.pop_front();
               n_checked++;
               if (rsp_tdata[47:46] !== 2'b00 || rsp_tdata[45:0] !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch at %0t\n  expected %s\n  actual   %s (pad %b)",
                              $realtime, fmt_date(want), fmt_date(date_t'(rsp_tdata[45:0])),
                              rsp_tdata[47:46]);
               end
            end
            rsp_stall = $urandom_range(0, rsp_stall_max);
         end
         if (rsp_stall != 0) begin
            rsp_stall--;
            nxt_ready = 1'b0;
         end else begin
            nxt_ready = 1'b1;
         end
      end
      rsp_tready <= nxt_ready;
   end

   task automatic queue_count(input logic [31:0] c);
      pending_counts.push_back(c);
      n_queued++;
   endtask

   // count that lands on the given local day and second under the current offset
   function automatic logic [31:0] at_local(input int unsigned day, input int unsigned sec);
      return 32'(day * DAY_SECONDS + sec) - {15'd0, zone_offset};
   endfunction

   task automatic wait_drained();
      while (n_checked != n_queued) @(posedge clock);
   endtask

   task automatic write_zone(input logic [16:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      zone_offset = value;
      n_zones++;
   endtask

   task automatic queue_random(input int n);
      int unsigned day, year;
      int          shift;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 3))
            0: queue_count($urandom);
            1: begin
               // around a new year
               year  = $urandom_range(2000, 2136);
               shift = $urandom_range(0, 4 * DAY_SECONDS) - 2 * DAY_SECONDS;
               queue_count(at_local(year_start(year), 0) + shift);
            end
            2: begin
               // first or last second of some day, or anywhere inside it
               day = $urandom_range(0, 49709);
               case ($urandom_range(0, 2))
                  0: queue_count(at_local(day, 0));
                  1: queue_count(at_local(day, DAY_SECONDS - 1));
                  default: queue_count(at_local(day, $urandom_range(0, DAY_SECONDS - 1)));
               endcase
            end
            default: queue_count(32'hFFFF_FFFF - $urandom_range(0, 200000));
         endcase
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset offset, including the wrap back to early 2000
      req_gap_max   = 11;
      rsp_stall_max = 11;
      queue_count(32'h0000_0000);
      queue_count(32'hFFFF_FFFF);
      queue_count(32'hFFFF_8F80);
      wait_drained();

      write_zone(17'd0);
      queue_count(at_local(0, 0));
      queue_count(at_local(0, 59));
      queue_count(at_local(0, 3599));
      queue_count(at_local(0, DAY_SECONDS - 1));
      queue_count(at_local(31, 0));
      queue_count(at_local(59, 43200));
      queue_count(at_local(60, 0));
      queue_count(at_local(365, DAY_SECONDS - 1));
      queue_count(at_local(366, 0));
      queue_count(at_local(year_start(2005) - 1, DAY_SECONDS - 1));
      // century year without a leap day
      queue_count(at_local(year_start(2100) + 58, DAY_SECONDS - 1));
      queue_count(at_local(year_start(2100) + 59, 0));
      queue_count(at_local(year_start(2101) - 1, 0));
      queue_count(32'hFFFF_FFFF);
      wait_drained();

      write_zone(17'd86399);
      queue_count(32'h0000_0000);
      queue_count(32'hFFFF_FFFF);
      queue_count(32'hFFFE_AE81);
      wait_drained();

      // offset beyond one day is added as it stands
      write_zone(17'h1FFFF);
      queue_count(32'h0000_0000);
      queue_count(32'hFFFF_FFFF);
      queue_count(32'hFFFE_0001);
      wait_drained();

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: write_zone(17'd0);
            1: write_zone(17'd86399);
            2: write_zone(17'h1FFFF);
            default: write_zone(17'($urandom_range(0, 86399)));
         endcase
         req_gap_max   = (p % 4 == 1) ? 0 : 11;
         rsp_stall_max = (p % 4 == 1 || p % 4 == 2) ? 0 : 11;
         queue_random(105);
         wait_drained();
      end

      repeat (100) @(posedge clock);
      if (expected_dates.size() != 0) fail_count++;
      $display("checked %0d conversions under %0d zone offset settings, %0d failures",
               n_checked, n_zones, fail_count);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout with %0d results outstanding", n_queued - n_checked);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
